[rtl/core/area_light_sample_point_macros.svh]
// Assertion macros for the area light sampler.
// Expects clk and rst_n in the scope of the file that includes it.
`ifndef AREA_LIGHT_SAMPLE_POINT_MACROS_SVH
`define AREA_LIGHT_SAMPLE_POINT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ALSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ALSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/alsp_pkg.sv]
// Shared constants, types and table builders for the area light sampler.
// No dependencies; used by alsp_tables and area_light_sample_point.
`timescale 1ns / 1ps

package alsp_pkg;

    localparam int unsigned SEQ_LEN    = 1024;
    localparam int unsigned CNT_W      = $clog2(SEQ_LEN);
    localparam int unsigned SQRT_SHIFT = 32 - CNT_W;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned RADIUS_W   = COORD_W - 1;
    localparam int unsigned SCALE_W    = 16;
    localparam int unsigned SCALED_W   = RADIUS_W + SCALE_W;
    localparam int unsigned QW_MAG_W   = 16;
    localparam int unsigned WAVE_W     = QW_MAG_W + 1;
    localparam int unsigned QUARTER    = SEQ_LEN / 4;
    localparam int unsigned QW_DEPTH   = QUARTER + 1;
    localparam int unsigned QW_IDX_W   = $clog2(QW_DEPTH);
    localparam int unsigned U_W        = 16;
    localparam int unsigned V_W        = CNT_W + 1;
    localparam int unsigned PA_W       = COORD_W + U_W;
    localparam int unsigned PB_W       = COORD_W + V_W;
    localparam int unsigned DP_W       = COORD_W + WAVE_W;
    localparam int unsigned WAVE_FRAC  = QW_MAG_W - 1;
    localparam int unsigned OFF_W      = DP_W - WAVE_FRAC;
    localparam int unsigned SUM_W      = OFF_W + 1;

    localparam logic [63:0] PI_Q30       = 64'd3373259426;
    localparam int unsigned TAYLOR_TERMS = 8;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_DISC  = 2'd1;
    localparam logic [1:0] KIND_RECT  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [SCALE_W-1:0]        scale;
        logic signed [WAVE_W-1:0] sin_v;
        logic signed [WAVE_W-1:0] cos_v;
    } alsp_lookup_t;

    // Radius scale entry: floor(sqrt(idx * 2^32 / SEQ_LEN)), digit by digit.
    function automatic logic [SCALE_W-1:0] sqrt_entry(input int unsigned idx);
        logic [33:0] n;
        logic [33:0] res;
        logic [33:0] bitv;
        int          i;
        n    = 34'(idx) << SQRT_SHIFT;
        res  = '0;
        bitv = 34'd1 << 30;
        for (i = 0; i < 16; i++)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[SCALE_W-1:0];
    endfunction

    // Quarter-wave entry j: sin(pi*j/512) by a truncated Taylor sum in Q2.30,
    // rounded half up to Q1.15.
    function automatic logic [QW_MAG_W-1:0] wave_entry(input int unsigned j);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        int                 n;
        x    = (PI_Q30 * 64'(j)) >> 9;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (n = 0; n < TAYLOR_TERMS; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n[0] == 1'b0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = '0;
        rounded = ($unsigned(sum) + 64'd16384) >> 15;
        return rounded[QW_MAG_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] rev_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        for (int b = 0; b < CNT_W; b++)
            r[b] = v[CNT_W-1-b];
        return r;
    endfunction

    function automatic coord_t saturate(input logic signed [SUM_W-1:0] v);
        coord_t r;
        if (v > SAT_HI)
            r = SAT_HI[COORD_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[COORD_W-1:0];
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

[rtl/core/alsp_tables.sv]
// Radius scale and sine/cosine tables with a registered read port.
// Depends on alsp_pkg for the table builders and the lookup struct.
`timescale 1ns / 1ps

module alsp_tables
    import alsp_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [CNT_W-1:0] k,
    output alsp_lookup_t     lookup
);

    logic [SCALE_W-1:0]  sqrt_rom [SEQ_LEN];
    logic [QW_MAG_W-1:0] wave_rom [QW_DEPTH];

    for (genvar g = 0; g < SEQ_LEN; g++)
    begin : g_sqrt
        assign sqrt_rom[g] = sqrt_entry(g);
    end

    for (genvar g = 0; g < QW_DEPTH; g++)
    begin : g_wave
        assign wave_rom[g] = wave_entry(g);
    end

    function automatic logic [QW_IDX_W-1:0] wave_index(input logic [CNT_W-1:0] a);
        logic [QW_IDX_W-1:0] r;
        r = QW_IDX_W'(a[CNT_W-3:0]);
        // odd quadrants run the quarter wave backwards
        if (a[CNT_W-2])
            return QW_IDX_W'(QUARTER) - r;
        return r;
    endfunction

    logic [CNT_W-1:0]    angle;
    logic [CNT_W-1:0]    cos_angle;
    logic [SCALE_W-1:0]  scale_reg;
    logic [QW_MAG_W-1:0] sin_mag_reg;
    logic [QW_MAG_W-1:0] cos_mag_reg;
    logic                sin_neg_reg;
    logic                cos_neg_reg;

    assign angle     = rev_cnt(k);
    assign cos_angle = angle + CNT_W'(QUARTER);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            scale_reg   <= sqrt_rom[k];
            sin_mag_reg <= wave_rom[wave_index(angle)];
            cos_mag_reg <= wave_rom[wave_index(cos_angle)];
            sin_neg_reg <= angle[CNT_W-1];
            cos_neg_reg <= cos_angle[CNT_W-1];
        end
    end

    logic signed [WAVE_W-1:0] sin_pos;
    logic signed [WAVE_W-1:0] cos_pos;

    assign sin_pos = $signed({1'b0, sin_mag_reg});
    assign cos_pos = $signed({1'b0, cos_mag_reg});

    assign lookup.scale = scale_reg;
    assign lookup.sin_v = sin_neg_reg ? -sin_pos : sin_pos;
    assign lookup.cos_v = cos_neg_reg ? -cos_pos : cos_pos;

endmodule

[rtl/core/area_light_sample_point.sv]
// Area light sampler top level: handshake, sample counter and datapath.
// Depends on alsp_pkg, alsp_tables and area_light_sample_point_macros.svh.
`timescale 1ns / 1ps
`include "area_light_sample_point_macros.svh"

// Usage
//   A request on the input channel (in_valid/in_ready) carries one light:
//   kind, centre, disc radius and two rectangle edges. The block returns one
//   sample point per request on the output channel (out_valid/out_ready).
//   Every request advances the 10-bit sample counter, whatever the kind.
// Sequence
//   The request passes through the states MUL1, MUL2 and FIN before its point
//   is registered, and no new request is taken until it has left FIN: table read
//   (radius scale, sine, cosine) as the request is taken, one multiply for the
//   radius scale and the rectangle products, one multiply for the disc rotation,
//   one final add with saturation. in_ready is high only while no request is in flight.
// Reset
//   rst_n clears the counter, so the first request uses sample index 1, and
//   empties the output register.
// Stall
//   A finished point waits in the output register while out_ready is low;
//   the next request is still taken and runs up to its final add, which
//   holds until the output register frees up.
module area_light_sample_point
    import alsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          light_kind,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic [30:0]         disc_radius,
    input  logic signed [31:0]  span_a_x,
    input  logic signed [31:0]  span_a_y,
    input  logic signed [31:0]  span_a_z,
    input  logic signed [31:0]  span_b_x,
    input  logic signed [31:0]  span_b_y,
    input  logic signed [31:0]  span_b_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  point_x,
    output logic signed [31:0]  point_y,
    output logic signed [31:0]  point_z
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             load_out;

    logic [1:0]          kind_reg;
    coord_t              pos_x_reg;
    coord_t              pos_y_reg;
    coord_t              pos_z_reg;
    logic [RADIUS_W-1:0] radius_reg;
    coord_t              span_a_x_reg;
    coord_t              span_a_y_reg;
    coord_t              span_a_z_reg;
    coord_t              span_b_x_reg;
    coord_t              span_b_y_reg;
    coord_t              span_b_z_reg;

    alsp_lookup_t lookup;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign cnt_next = accept ? cnt_reg + 1'b1 : cnt_reg;

    alsp_tables u_tables (
        .clk    (clk),
        .rd_en  (accept),
        .k      (cnt_next),
        .lookup (lookup)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_FIN;
            ST_FIN:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request fields for the whole computation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= light_kind;
            pos_x_reg    <= pos_x;
            pos_y_reg    <= pos_y;
            pos_z_reg    <= pos_z;
            radius_reg   <= disc_radius;
            span_a_x_reg <= span_a_x;
            span_a_y_reg <= span_a_y;
            span_a_z_reg <= span_a_z;
            span_b_x_reg <= span_b_x;
            span_b_y_reg <= span_b_y;
            span_b_z_reg <= span_b_z;
        end
    end

    // First multiply: radius scale and rectangle edge weights.
    logic [CNT_W-1:0]          rev_k;
    logic signed [U_W-1:0]     u_w;
    logic signed [V_W-1:0]     v_w;
    logic [SCALED_W-1:0]       scaled;
    logic [RADIUS_W-1:0]       r_next;
    logic [RADIUS_W-1:0]       r_reg;
    logic signed [PA_W-1:0]    pa_x_next;
    logic signed [PA_W-1:0]    pa_y_next;
    logic signed [PA_W-1:0]    pa_z_next;
    logic signed [PB_W-1:0]    pb_x_next;
    logic signed [PB_W-1:0]    pb_y_next;
    logic signed [PB_W-1:0]    pb_z_next;
    logic signed [PA_W-1:0]    pa_x_reg;
    logic signed [PA_W-1:0]    pa_y_reg;
    logic signed [PA_W-1:0]    pa_z_reg;
    logic signed [PB_W-1:0]    pb_x_reg;
    logic signed [PB_W-1:0]    pb_y_reg;
    logic signed [PB_W-1:0]    pb_z_reg;

    assign rev_k = rev_cnt(cnt_reg);
    // rev16(k) - 32768: flip the top bit of the reversed index
    assign u_w = $signed({~rev_k[CNT_W-1], rev_k[CNT_W-2:0], {(U_W - CNT_W){1'b0}}});
    // 2k - SEQ_LEN: flip the top bit of 2k
    assign v_w = $signed({~cnt_reg[CNT_W-1], cnt_reg[CNT_W-2:0], 1'b0});

    assign scaled    = SCALED_W'(radius_reg) * SCALED_W'(lookup.scale);
    assign r_next    = scaled[SCALED_W-1:SCALE_W];
    assign pa_x_next = PA_W'(span_a_x_reg) * PA_W'(u_w);
    assign pa_y_next = PA_W'(span_a_y_reg) * PA_W'(u_w);
    assign pa_z_next = PA_W'(span_a_z_reg) * PA_W'(u_w);
    assign pb_x_next = PB_W'(span_b_x_reg) * PB_W'(v_w);
    assign pb_y_next = PB_W'(span_b_y_reg) * PB_W'(v_w);
    assign pb_z_next = PB_W'(span_b_z_reg) * PB_W'(v_w);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL1)
        begin
            r_reg    <= r_next;
            pa_x_reg <= pa_x_next;
            pa_y_reg <= pa_y_next;
            pa_z_reg <= pa_z_next;
            pb_x_reg <= pb_x_next;
            pb_y_reg <= pb_y_next;
            pb_z_reg <= pb_z_next;
        end
    end

    // Second multiply: rotate the disc radius; rectangle terms floor and add.
    logic signed [COORD_W-1:0] r_s;
    logic signed [DP_W-1:0]    dp_x;
    logic signed [DP_W-1:0]    dp_z;
    logic signed [OFF_W-1:0]   disc_x;
    logic signed [OFF_W-1:0]   disc_z;
    logic signed [OFF_W-1:0]   rect_x;
    logic signed [OFF_W-1:0]   rect_y;
    logic signed [OFF_W-1:0]   rect_z;
    logic signed [OFF_W-1:0]   off_x_next;
    logic signed [OFF_W-1:0]   off_y_next;
    logic signed [OFF_W-1:0]   off_z_next;
    logic signed [OFF_W-1:0]   off_x_reg;
    logic signed [OFF_W-1:0]   off_y_reg;
    logic signed [OFF_W-1:0]   off_z_reg;

    assign r_s    = $signed({1'b0, r_reg});
    assign dp_x   = DP_W'(r_s) * DP_W'(lookup.cos_v);
    assign dp_z   = DP_W'(r_s) * DP_W'(lookup.sin_v);
    assign disc_x = $signed(dp_x[DP_W-1:WAVE_FRAC]);
    assign disc_z = $signed(dp_z[DP_W-1:WAVE_FRAC]);

    assign rect_x = OFF_W'($signed(pa_x_reg[PA_W-1:U_W]))
                  + OFF_W'($signed(pb_x_reg[PB_W-1:V_W]));
    assign rect_y = OFF_W'($signed(pa_y_reg[PA_W-1:U_W]))
                  + OFF_W'($signed(pb_y_reg[PB_W-1:V_W]));
    assign rect_z = OFF_W'($signed(pa_z_reg[PA_W-1:U_W]))
                  + OFF_W'($signed(pb_z_reg[PB_W-1:V_W]));

    always_comb
    begin
        case (kind_reg)
            KIND_DISC:
            begin
                off_x_next = disc_x;
                off_y_next = '0;
                off_z_next = disc_z;
            end
            KIND_RECT:
            begin
                off_x_next = rect_x;
                off_y_next = rect_y;
                off_z_next = rect_z;
            end
            default:
            begin
                off_x_next = '0;
                off_y_next = '0;
                off_z_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL2)
        begin
            off_x_reg <= off_x_next;
            off_y_reg <= off_y_next;
            off_z_reg <= off_z_next;
        end
    end

    // Final add and saturate into the output register.
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    coord_t                  point_x_reg;
    coord_t                  point_y_reg;
    coord_t                  point_z_reg;

    assign sum_x = SUM_W'(pos_x_reg) + SUM_W'(off_x_reg);
    assign sum_y = SUM_W'(pos_y_reg) + SUM_W'(off_y_reg);
    assign sum_z = SUM_W'(pos_z_reg) + SUM_W'(off_z_reg);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            point_x_reg <= saturate(sum_x);
            point_y_reg <= saturate(sum_y);
            point_z_reg <= saturate(sum_z);
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign point_z   = point_z_reg;

    `ALSP_ASSERT_NEXT(a_cnt_advance, in_valid && in_ready, cnt_reg == CNT_W'($past(cnt_reg) + 1'b1), "sample counter did not advance on a request")
    `ALSP_ASSERT_NEXT(a_cnt_hold, !(in_valid && in_ready), $stable(cnt_reg), "sample counter moved without a request")
    `ALSP_ASSERT_NEXT(a_result_load, state_reg == ST_FIN && (!out_valid || out_ready), out_valid && state_reg == ST_IDLE, "finished point not loaded")
    `ALSP_ASSERT_NOW(a_point_offset, state_reg == ST_FIN && kind_reg != KIND_DISC && kind_reg != KIND_RECT, off_x_reg == '0 && off_y_reg == '0 && off_z_reg == '0, "point light got a nonzero offset")

endmodule

[test/area_light_sample_point_tb.sv]
// Testbench for area_light_sample_point: drives light requests, predicts each
// sample point and checks it against the output channel.
// Depends on alsp_pkg and the area_light_sample_point RTL.
`timescale 1ns / 1ps

module area_light_sample_point_tb;
    import alsp_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        coord_t      pos_x;
        coord_t      pos_y;
        coord_t      pos_z;
        logic [30:0] radius;
        coord_t      a_x;
        coord_t      a_y;
        coord_t      a_z;
        coord_t      b_x;
        coord_t      b_y;
        coord_t      b_z;
    } light_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  light_kind = KIND_POINT;
    coord_t      pos_x = '0;
    coord_t      pos_y = '0;
    coord_t      pos_z = '0;
    logic [30:0] disc_radius = '0;
    coord_t      span_a_x = '0;
    coord_t      span_a_y = '0;
    coord_t      span_a_z = '0;
    coord_t      span_b_x = '0;
    coord_t      span_b_y = '0;
    coord_t      span_b_z = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    coord_t      point_x;
    coord_t      point_y;
    coord_t      point_z;

    // Predictor state
    logic [15:0] root_lut [1024];
    longint      quarter_lut [257];
    logic [9:0]  model_count = '0;
    point_t      pending_points [$];

    int mismatch_count = 0;
    int points_checked = 0;
    int lights_sent = 0;
    int kind_count [4] = '{0, 0, 0, 0};
    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;
    int sink_hold_cycles = 0;

    area_light_sample_point i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .light_kind  (light_kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .disc_radius (disc_radius),
        .span_a_x    (span_a_x),
        .span_a_y    (span_a_y),
        .span_a_z    (span_a_z),
        .span_b_x    (span_b_x),
        .span_b_y    (span_b_y),
        .span_b_z    (span_b_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- tables

    function automatic logic [15:0] root_of(input longint unsigned n);
        longint unsigned s;
        longint unsigned t;
        s = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = s | (64'd1 << b);
            if (t * t <= n)
                s = t;
        end
        return s[15:0];
    endfunction

    function automatic void build_luts();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k < 1024; k++)
            root_lut[k] = root_of(longint'(k) << 22);
        // sin(pi*j/512) by x and 8 further Taylor terms in Q2.30, rounded half up to Q1.15
        for (int j = 0; j <= 256; j++)
        begin
            x    = (64'd3373259426 * longint'(j)) / 64'd512;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            quarter_lut[j] = (acc + 16384) >>> 15;
        end
    endfunction

    // ------------------------------------------------------------- predictor

    function automatic logic [9:0] reverse10(input logic [9:0] v);
        logic [9:0] r;
        for (int b = 0; b < 10; b++)
            r[b] = v[9-b];
        return r;
    endfunction

    function automatic longint wave_at(input logic [9:0] a);
        longint mag;
        mag = a[8] ? quarter_lut[256 - a[7:0]] : quarter_lut[a[7:0]];
        return a[9] ? -mag : mag;
    endfunction

    function automatic coord_t clamp(input longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return v[31:0];
    endfunction

    function automatic point_t sample_point_of(input light_t l, input logic [9:0] k);
        longint px;
        longint py;
        longint pz;
        longint r;
        longint u;
        longint v;
        logic [9:0] a;
        point_t p;
        px = longint'(l.pos_x);
        py = longint'(l.pos_y);
        pz = longint'(l.pos_z);
        a  = reverse10(k);
        if (l.kind == KIND_DISC)
        begin
            r  = (longint'(l.radius) * longint'(root_lut[k])) >>> 16;
            px = px + ((r * wave_at(a + 10'd256)) >>> 15);
            pz = pz + ((r * wave_at(a)) >>> 15);
        end
        else if (l.kind == KIND_RECT)
        begin
            u  = longint'(a) * 64 - 32768;
            v  = 2 * longint'(k) - 1024;
            // power-of-two divisors: arithmetic shift is the floor
            px = px + ((longint'(l.a_x) * u) >>> 16) + ((longint'(l.b_x) * v) >>> 11);
            py = py + ((longint'(l.a_y) * u) >>> 16) + ((longint'(l.b_y) * v) >>> 11);
            pz = pz + ((longint'(l.a_z) * u) >>> 16) + ((longint'(l.b_z) * v) >>> 11);
        end
        p.x = clamp(px);
        p.y = clamp(py);
        p.z = clamp(pz);
        return p;
    endfunction

    // -------------------------------------------------------------- stimulus

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic coord_t random_coord();
        coord_t v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return v >>> 11;
            default: return v;
        endcase
    endfunction

    function automatic logic [30:0] random_radius();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return v[30:0] >> 12;
            default: return v[30:0];
        endcase
    endfunction

    function automatic light_t random_light(input logic [1:0] kind);
        light_t l;
        l.kind   = kind;
        l.pos_x  = random_coord();
        l.pos_y  = random_coord();
        l.pos_z  = random_coord();
        l.radius = random_radius();
        l.a_x    = random_coord();
        l.a_y    = random_coord();
        l.a_z    = random_coord();
        l.b_x    = random_coord();
        l.b_y    = random_coord();
        l.b_z    = random_coord();
        return l;
    endfunction

    function automatic logic [1:0] random_kind();
        // wrap the counter onto a rectangle so the zero index hits a real offset
        if (model_count == 10'd1023)
            return KIND_RECT;
        case ($urandom_range(0, 9))
            0: return KIND_POINT;
            1: return KIND_OTHER;
            2, 3, 4, 5: return KIND_DISC;
            default: return KIND_RECT;
        endcase
    endfunction

    task automatic offer_light(input light_t l);
        int gap;
        gap = (!src_steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        light_kind  <= l.kind;
        pos_x       <= l.pos_x;
        pos_y       <= l.pos_y;
        pos_z       <= l.pos_z;
        disc_radius <= l.radius;
        span_a_x    <= l.a_x;
        span_a_y    <= l.a_y;
        span_a_z    <= l.a_z;
        span_b_x    <= l.b_x;
        span_b_y    <= l.b_y;
        span_b_z    <= l.b_z;
        do
            @(posedge clk);
        while (!in_ready);
        model_count = model_count + 10'd1;
        pending_points.push_back(sample_point_of(l, model_count));
        lights_sent++;
        kind_count[l.kind]++;
    endtask

    task automatic wait_all_points();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_lights(input int count);
        for (int i = 0; i < count; i++)
            offer_light(random_light(random_kind()));
    endtask

    // ----------------------------------------------------------------- tests

    task automatic test_point_lights();
        light_t l;
        l = random_light(KIND_POINT);
        l.pos_x = COORD_MAX;
        l.pos_y = COORD_MIN;
        l.pos_z = '0;
        offer_light(l);
        l = random_light(KIND_OTHER);
        l.pos_x = COORD_MIN;
        l.pos_y = COORD_MAX;
        l.pos_z = 32'sh0001_0000;
        offer_light(l);
        // unused radius and spans at their extremes must not leak in
        l = random_light(KIND_POINT);
        l.radius = '1;
        {l.a_x, l.a_y, l.a_z} = {3{COORD_MAX}};
        {l.b_x, l.b_y, l.b_z} = {3{COORD_MIN}};
        offer_light(l);
        l.kind = KIND_OTHER;
        offer_light(l);
        wait_all_points();
    endtask

    task automatic test_disc_lights();
        light_t l;
        l = random_light(KIND_DISC);
        l.radius = '0;
        offer_light(l);
        l.radius = '1;
        {l.pos_x, l.pos_y, l.pos_z} = {3{32'sh0}};
        offer_light(l);
        {l.pos_x, l.pos_y, l.pos_z} = {COORD_MAX, COORD_MIN, COORD_MIN};
        offer_light(l);
        {l.pos_x, l.pos_y, l.pos_z} = {COORD_MIN, COORD_MAX, COORD_MAX};
        offer_light(l);
        {l.a_x, l.b_z} = {COORD_MAX, COORD_MIN};
        offer_light(l);
        offer_light(random_light(KIND_DISC));
        wait_all_points();
    endtask

    task automatic test_rect_lights();
        light_t l;
        l = random_light(KIND_RECT);
        {l.a_x, l.a_y, l.a_z, l.b_x, l.b_y, l.b_z} = {6{COORD_MAX}};
        {l.pos_x, l.pos_y, l.pos_z} = {3{COORD_MAX}};
        offer_light(l);
        {l.pos_x, l.pos_y, l.pos_z} = {3{COORD_MIN}};
        offer_light(l);
        {l.a_x, l.a_y, l.a_z, l.b_x, l.b_y, l.b_z} = {6{COORD_MIN}};
        offer_light(l);
        {l.pos_x, l.pos_y, l.pos_z} = {3{COORD_MAX}};
        offer_light(l);
        {l.a_x, l.a_y, l.a_z, l.b_x, l.b_y, l.b_z} = {6{32'sh0}};
        l.radius = '1;
        offer_light(l);
        {l.a_x, l.a_y, l.a_z} = {COORD_MAX, COORD_MIN, 32'sh0001_0000};
        {l.b_x, l.b_y, l.b_z} = {COORD_MIN, COORD_MAX, -32'sh0001_0000};
        offer_light(l);
        wait_all_points();
    endtask

    // hold the receiver off while requests keep coming, so the block backs up
    task automatic test_output_stall();
        src_steady = 1'b1;
        sink_hold_cycles = 300;
        send_random_lights(24);
        src_steady = 1'b0;
        wait_all_points();
    endtask

    task automatic test_back_to_back();
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        send_random_lights(200);
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        wait_all_points();
    endtask

    task automatic test_random_mix();
        send_random_lights(650);
        wait_all_points();
        send_random_lights(676);
        wait_all_points();
    endtask

    // -------------------------------------------------------------- receiver

    initial
    begin
        int stall;
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!sink_steady && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what, input coord_t got, input coord_t want);
        $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_points.size() == 0)
            begin
                report_mismatch("point with no request pending", point_x, '0);
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_x !== want.x)
                    report_mismatch("point_x", point_x, want.x);
                if (point_y !== want.y)
                    report_mismatch("point_y", point_y, want.y);
                if (point_z !== want.z)
                    report_mismatch("point_z", point_z, want.z);
                points_checked++;
            end
        end
    end

    // ------------------------------------------------------------------ main

    initial
    begin
        build_luts();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_point_lights();
        test_disc_lights();
        test_rect_lights();
        test_output_stall();
        test_back_to_back();
        test_random_mix();

        repeat (10) @(posedge clk);
        $display("Sent %0d lights: %0d point, %0d disc, %0d rectangle, %0d other kind;",
                 lights_sent, kind_count[KIND_POINT], kind_count[KIND_DISC],
                 kind_count[KIND_RECT], kind_count[KIND_OTHER]);
        $display("checked %0d sample points across a counter wrap and long output stalls.",
                 points_checked);
        if (mismatch_count == 0 && pending_points.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[area_light_sample_point.f]
+incdir+rtl/core
rtl/core/alsp_pkg.sv
rtl/core/alsp_tables.sv
rtl/core/area_light_sample_point.sv
test/area_light_sample_point_tb.sv
